/* rtl/spvg_pkg.sv */
// Package for the star polygon vertex generator: constants, types, CORDIC table.
// No dependencies.
`timescale 1ns / 1ps
package spvg_pkg;

	localparam int MAX_POINTS        = 32;
	localparam int CORDIC_ITERATIONS = 16;
	localparam int TABLE_LEN         = 24;
	localparam int NUM_ITER = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS : TABLE_LEN;
	localparam int ITER_W   = $clog2(NUM_ITER + 1);
	localparam int PTS_W    = 6;
	localparam int VNUM_W   = 6;
	localparam int RATIO_W  = 16;
	localparam int CFG_W    = 16;

	localparam logic [PTS_W-1:0]   MIN_PTS    = 6'd3;
	localparam logic [PTS_W-1:0]   MAX_PTS    = PTS_W'(MAX_POINTS);
	localparam logic [RATIO_W-1:0] RATIO_LOW  = 16'd6554;
	localparam logic [RATIO_W-1:0] RATIO_HIGH = 16'd58982;
	localparam logic [PTS_W-1:0]   PTS_RESET  = 6'd5;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd32768;

	localparam logic [34:0] GAIN_INV = 35'd652032874;

	typedef enum logic {
		REG_STAR_POINTS = 1'b0,
		REG_INNER_RATIO = 1'b1
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INNER, ST_ANGLE_DIV, ST_CORDIC, ST_MUL_X, ST_MUL_Y,
		ST_SUM, ST_OUT
	} state_t;

	typedef struct packed {
		logic load;      // capture input item
		logic inner_mul; // inner radius product
		logic div_start; // start angle divider for current vertex
		logic div_step;
		logic cord_start;
		logic cord_step;
		logic mul_x;
		logic mul_y;
		logic sum;
		logic next_vertex;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic cord_done;
		logic last;
	} sts_t;

	function automatic logic [31:0] atan_lut(input logic [4:0] k);
		logic [31:0] r;
		case (k)
			5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/spvg_if.sv */
// Valid/ready channel interfaces for input and result items.
// Depends on nothing.
`timescale 1ns / 1ps
interface spvg_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] center_x;
	logic signed [31:0] center_y;
	logic        [30:0] outer_radius;
	modport source (output valid, center_x, center_y, outer_radius, input ready);
	modport sink   (input valid, center_x, center_y, outer_radius, output ready);
endinterface

interface spvg_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vertex_x;
	logic signed [31:0] vertex_y;
	logic        [5:0]  vertex_number;
	logic               last_vertex;
	modport source (output valid, vertex_x, vertex_y, vertex_number, last_vertex, input ready);
	modport sink   (input valid, vertex_x, vertex_y, vertex_number, last_vertex, output ready);
endinterface

/* rtl/spvg_ctrl.sv */
// Controller state machine: sequences per-vertex angle, CORDIC, scale and output.
// Depends on spvg_pkg.
`timescale 1ns / 1ps
module spvg_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  spvg_pkg::sts_t  sts,
	output spvg_pkg::cmd_t  cmd
);
	import spvg_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_INNER;
				end
			end
			ST_INNER: begin
				cmd.inner_mul = 1'b1;
				cmd.div_start = 1'b1;
				state_d       = ST_ANGLE_DIV;
			end
			ST_ANGLE_DIV: begin
				if (sts.div_done) begin
					cmd.cord_start = 1'b1;
					state_d        = ST_CORDIC;
				end else cmd.div_step = 1'b1;
			end
			ST_CORDIC: begin
				if (sts.cord_done) state_d = ST_MUL_X;
				else cmd.cord_step = 1'b1;
			end
			ST_MUL_X: begin
				cmd.mul_x = 1'b1;
				state_d   = ST_MUL_Y;
			end
			ST_MUL_Y: begin
				cmd.mul_y = 1'b1;
				state_d   = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.last) state_d = ST_IDLE;
					else begin
						cmd.next_vertex = 1'b1;
						cmd.div_start   = 1'b1;
						state_d         = ST_ANGLE_DIV;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

/* rtl/spvg_datapath.sv */
// Datapath: config registers, angle divider, iterative CORDIC, scaling, saturation.
// Depends on spvg_pkg.
`timescale 1ns / 1ps
module spvg_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [spvg_pkg::CFG_W-1:0]   cfg_data,
	input  logic signed [31:0]           center_x,
	input  logic signed [31:0]           center_y,
	input  logic [30:0]                  outer_radius,
	input  spvg_pkg::cmd_t               cmd,
	output spvg_pkg::sts_t               sts,
	output logic signed [31:0]           vertex_x,
	output logic signed [31:0]           vertex_y,
	output logic [spvg_pkg::VNUM_W-1:0]  vertex_number,
	output logic                         last_vertex
);
	import spvg_pkg::*;

	logic [PTS_W-1:0]   pts_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [PTS_W-1:0]   wp;
	logic [RATIO_W-1:0] wr;

	// clamp on write
	always_comb begin
		wp = cfg_data[PTS_W-1:0];
		if (wp < MIN_PTS) wp = MIN_PTS;
		else if (wp > MAX_PTS) wp = MAX_PTS;
		wr = cfg_data[RATIO_W-1:0];
		if (wr < RATIO_LOW) wr = RATIO_LOW;
		else if (wr > RATIO_HIGH) wr = RATIO_HIGH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q   <= PTS_RESET;
			ratio_q <= RATIO_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				REG_STAR_POINTS: pts_q   <= wp;
				REG_INNER_RATIO: ratio_q <= wr;
				default: ;
			endcase
		end
	end

	// item registers
	logic signed [31:0] cx_q, cy_q;
	logic [30:0]        outer_q, inner_q;
	logic [VNUM_W-1:0]  vnum_q;
	logic [VNUM_W:0]    nlast;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q    <= center_x;
			cy_q    <= center_y;
			outer_q <= outer_radius;
			vnum_q  <= '0;
		end
		if (cmd.inner_mul)
			inner_q <= 31'((48'(outer_q) * 48'(ratio_q) + 48'd32768) >> 16);
		if (cmd.next_vertex) vnum_q <= vnum_q + 1'b1;
	end

	assign nlast = {pts_q, 1'b0} - 1'b1;
	assign sts.last = (VNUM_W + 1)'(vnum_q) == nlast;

	// restoring divider: (i*32768 + P/2) / P, quotient fits 16 bits
	localparam int DIVN_W = VNUM_W + 15;
	logic [DIVN_W-1:0] dnum_q;
	logic [PTS_W:0]    drem_q;
	logic [4:0]        dcnt_q;
	logic [PTS_W:0]    dtry;

	assign dtry = {drem_q[PTS_W-1:0], dnum_q[DIVN_W-1]};
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dnum_q <= DIVN_W'({(cmd.next_vertex ? vnum_q + 1'b1 : vnum_q), 15'd0})
				+ DIVN_W'(pts_q >> 1);
			drem_q <= '0;
			dcnt_q <= 5'(DIVN_W);
		end else if (cmd.div_step) begin
			if (dtry >= {1'b0, pts_q}) begin
				drem_q <= dtry - {1'b0, pts_q};
				dnum_q <= {dnum_q[DIVN_W-2:0], 1'b1};
			end else begin
				drem_q <= dtry;
				dnum_q <= {dnum_q[DIVN_W-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q - 1'b1;
		end
	end
	assign sts.div_done = dcnt_q == 5'd0;

	// CORDIC, one iteration per cycle
	logic [15:0]        a16;
	logic signed [31:0] z0;
	logic signed [34:0] x_q, y_q;
	logic signed [32:0] z_q;
	logic               flip_q;
	logic [ITER_W-1:0]  k_q;
	logic [4:0]         k5;

	assign a16 = 16'hC000 + dnum_q[15:0];
	assign z0  = {a16, 16'd0};
	assign k5  = 5'(k_q);

	always_ff @(posedge clk) begin
		if (cmd.cord_start) begin
			x_q <= GAIN_INV;
			y_q <= '0;
			k_q <= '0;
			if (a16[15:14] == 2'b01 || a16[15:14] == 2'b10) begin
				z_q    <= 33'(z0) ^ {1'b1, 32'h80000000} ^ {1'b0, 32'h0} ;
				flip_q <= 1'b1;
			end else begin
				z_q    <= 33'(z0);
				flip_q <= 1'b0;
			end
		end else if (cmd.cord_step) begin
			if (!z_q[32]) begin
				x_q <= x_q - (y_q >>> k5);
				y_q <= y_q + (x_q >>> k5);
				z_q <= z_q - $signed({1'b0, atan_lut(k5)});
			end else begin
				x_q <= x_q + (y_q >>> k5);
				y_q <= y_q - (x_q >>> k5);
				z_q <= z_q + $signed({1'b0, atan_lut(k5)});
			end
			k_q <= k_q + 1'b1;
		end
	end
	assign sts.cord_done = k_q == ITER_W'(NUM_ITER);

	// scale: one multiply per cycle, then add and saturate
	logic signed [31:0] r_s;
	logic signed [34:0] c_s, s_s, t;
	logic signed [66:0] px_q, py_q, prod;
	logic signed [37:0] sx, sy;
	logic signed [31:0] vx_q, vy_q;

	assign r_s = $signed({1'b0, vnum_q[0] ? inner_q : outer_q});
	assign c_s = flip_q ? -x_q : x_q;
	assign s_s = flip_q ? -y_q : y_q;
	assign t   = cmd.mul_x ? c_s : s_s;
	assign prod = 67'(r_s) * 67'(t) + 67'sd536870912;

	always_ff @(posedge clk) begin
		if (cmd.mul_x) px_q <= prod;
		if (cmd.mul_y) py_q <= prod;
	end

	function automatic logic signed [31:0] sat(input logic signed [37:0] v);
		if (v > 38'sd2147483647) return 32'h7FFFFFFF;
		if (v < -38'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	assign sx = 38'(cx_q) + 38'(px_q >>> 30);
	assign sy = 38'(cy_q) + 38'(py_q >>> 30);
	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			vx_q <= sat(sx);
			vy_q <= sat(sy);
		end
	end

	assign vertex_x      = vx_q;
	assign vertex_y      = vy_q;
	assign vertex_number = vnum_q;
	assign last_vertex   = sts.last;
endmodule

/* rtl/star_polygon_vertex_generator_core.sv */
// Top level of the star polygon vertex generator.
// Depends on spvg_pkg, spvg_if, spvg_ctrl, spvg_datapath.
`timescale 1ns / 1ps
// One input item (centre, outer radius) yields 2*star_points result items, one
// per vertex, vertex_number counting from 0 and last_vertex set on the final one.
// The block works on one star at a time. For each vertex it runs the bit-serial
// angle divider (21 steps, its done check starting the CORDIC), the iterative
// CORDIC (16 steps), the x and y multiplies, the add/saturate step and the
// output state, which holds the vertex while the receiver is not ready. A star
// runs from the accept through the inner radius step, then its 2*P vertices.
// Config writes take effect at once and are clamped to the legal range.
module star_polygon_vertex_generator_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [spvg_pkg::CFG_W-1:0]   cfg_data,
	spvg_in_if.sink                      in_ch,
	spvg_out_if.source                   out_ch
);
	import spvg_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// controller: sequencing only
	spvg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	// datapath: registers, divider, CORDIC, scaler
	spvg_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.center_x(in_ch.center_x), .center_y(in_ch.center_y),
		.outer_radius(in_ch.outer_radius),
		.cmd(cmd), .sts(sts),
		.vertex_x(out_ch.vertex_x), .vertex_y(out_ch.vertex_y),
		.vertex_number(out_ch.vertex_number), .last_vertex(out_ch.last_vertex)
	);
endmodule

/* rtl/spvg_checker.sv */
// Port-level checks for the star polygon vertex generator, bound to the top.
// Depends on spvg_if.
`timescale 1ns / 1ps
module spvg_checker (
	input logic clk,
	input logic arst_n,
	spvg_in_if.sink    in_ch,
	spvg_out_if.source out_ch
);
	// no new item while a star is still being emitted
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("ready during output");
	// first vertex after an accept is number zero
	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> (out_ch.vertex_number == 6'd0))
		else $error("first vertex not zero");
	// last vertex has odd number
	a_last_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.last_vertex) |-> out_ch.vertex_number[0])
		else $error("last vertex even");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.vertex_x)))
		else $error("result dropped");
endmodule

bind star_polygon_vertex_generator_core spvg_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch)
);

/* bench/star_polygon_vertex_generator_core_tb.sv */
// Testbench for star_polygon_vertex_generator_core: directed table, then random stars,
// each vertex checked against a CORDIC vertex predictor. Depends on the core, spvg_pkg, spvg_if.
`timescale 1ns / 1ps
module star_polygon_vertex_generator_core_tb;
	import spvg_pkg::*;

	localparam int          N_RANDOM    = 205;
	localparam int          CYCLE_LIMIT = 3000000;
	localparam int          SETTLE      = 80;   // wait before register writes and at the end
	localparam int          HOLD_CYCLES = 4000; // long receiver hold-off
	localparam longint      START_X     = 652032874;
	localparam longint      HALF_ROUND  = 64'sd1 <<< 29;
	localparam longint      Q_TURN      = 64'sd1073741824;
	localparam longint      H_TURN      = 64'sd2147483648;
	localparam longint      S32_MAX     = 64'sd2147483647;
	localparam longint      S32_MIN     = -64'sd2147483648;

	// atan(2^-k) in 2^32 units per turn
	localparam longint ARCTAN [TABLE_LEN] = '{
		'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
		'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
		'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
		'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [5:0]         num;
		logic               last;
	} vertex_t;

	// one directed row: optional register writes, then one star;
	// with at_centre set, vertex 0 is typed in as the centre (zero radius)
	typedef struct {
		bit                 set_pts;
		logic [15:0]        pts;
		bit                 set_ratio;
		logic [15:0]        ratio;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [30:0]        radius;
		bit                 at_centre;
	} star_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	cfg_index_t cfg_index = REG_STAR_POINTS;
	logic [CFG_W-1:0] cfg_data = '0;

	spvg_in_if  in_ch ();
	spvg_out_if out_ch ();

	star_polygon_vertex_generator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always #6 clk = ~clk;

	// mirror of the block's registers
	int unsigned tips = PTS_RESET;
	int unsigned ratio = RATIO_RESET;

	vertex_t pending_vertices [$];
	int      n_errors = 0;
	int      n_vertices = 0;
	longint  cycle_count = 0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.center_x = '0;
		in_ch.center_y = '0;
		in_ch.outer_radius = '0;
		out_ch.ready = 1'b0;
	end

	// cycle guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic longint floor_round30(longint r, longint t);
		return (r * t + HALF_ROUND) >>> 30;
	endfunction

	function automatic logic signed [31:0] sat_add(longint a, longint b);
		longint s;
		s = a + b;
		if (s > S32_MAX) s = S32_MAX;
		if (s < S32_MIN) s = S32_MIN;
		return s[31:0];
	endfunction

	// rotation-mode CORDIC; angle in 1/65536 turns, outputs Q2.30
	task automatic rotate_unit(input logic [15:0] a16, output longint c, output longint s);
		longint z, x, y, nx, dx, dy;
		bit flip;
		z = longint'($signed({a16, 16'h0000}));
		x = START_X;
		y = 0;
		flip = 0;
		if (z >= Q_TURN) begin
			z -= H_TURN; flip = 1;
		end else if (z < -Q_TURN) begin
			z += H_TURN; flip = 1;
		end
		for (int k = 0; k < NUM_ITER; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				nx = x - dx; y = y + dy; z -= ARCTAN[k];
			end else begin
				nx = x + dx; y = y - dy; z += ARCTAN[k];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	// queue every vertex of one star
	task automatic predict_star(input logic signed [31:0] cx, input logic signed [31:0] cy,
			input logic [30:0] outer);
		longint inner, r, c, s;
		int unsigned n;
		logic [15:0] a16;
		vertex_t v;
		inner = (longint'(outer) * longint'(ratio) + 32768) >>> 16;
		n = 2 * tips;
		for (int unsigned i = 0; i < n; i++) begin
			a16 = 16'(32'hC000 + (i * 32768 + tips / 2) / tips);
			r = i[0] ? inner : longint'(outer);
			rotate_unit(a16, c, s);
			v.x = sat_add(cx, floor_round30(r, c));
			v.y = sat_add(cy, floor_round30(r, s));
			v.num = i[5:0];
			v.last = (i == n - 1);
			pending_vertices.push_back(v);
		end
	endtask

	// registers change only with nothing in flight
	task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
		wait (pending_vertices.size() == 0);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_STAR_POINTS) begin
			tips = val[5:0];
			if (tips < MIN_PTS) tips = MIN_PTS;
			if (tips > MAX_PTS) tips = MAX_PTS;
		end else begin
			ratio = val;
			if (ratio < RATIO_LOW) ratio = RATIO_LOW;
			if (ratio > RATIO_HIGH) ratio = RATIO_HIGH;
		end
	endtask

	// offer one star after a random gap; expectations are queued on acceptance
	task automatic send_star(input logic signed [31:0] cx, input logic signed [31:0] cy,
			input logic [30:0] radius, input bit at_centre);
		int gap;
		int base;
		gap = $urandom_range(0, 9);
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.center_x = cx;
		in_ch.center_y = cy;
		in_ch.outer_radius = radius;
		do @(posedge clk); while (!in_ch.ready);
		base = pending_vertices.size();
		predict_star(cx, cy, radius);
		if (at_centre) begin
			pending_vertices[base].x = cx;
			pending_vertices[base].y = cy;
		end
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	star_row_t rows [] = '{
		// reset settings: five tips, half ratio
		'{0, 0, 0, 0, 32'sh0000_0000, 32'sh0000_0000, 31'd0, 1},
		'{0, 0, 0, 0, 32'sh0010_0000, -32'sh0008_0000, 31'h0004_0000, 0},
		// tips below three clamp to three
		'{1, 16'd0, 0, 0, 32'sh7FFF_FFFF, -32'sh8000_0000, 31'd0, 1},
		'{0, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 0},
		'{0, 0, 0, 0, -32'sh8000_0000, -32'sh8000_0000, 31'h7FFF_FFFF, 0},
		// upper bits of the write are dropped: 0x42 keeps 2, which clamps to 3
		'{1, 16'h0042, 1, 16'd0, 32'sh0001_0000, 32'sh0002_0000, 31'h0100_0000, 0},
		// tips above the maximum clamp, ratio high clamps
		'{1, 16'd63, 1, 16'hFFFF, 32'sh0000_0000, 32'sh0000_0000, 31'h0064_0000, 0},
		'{0, 0, 0, 0, 32'sh7FFF_0000, -32'sh7FFF_0000, 31'h7FFF_FFFF, 0},
		'{1, 16'd32, 1, 16'd6554, -32'sh0123_4567, 32'sh0765_4321, 31'h0001_0000, 0},
		'{1, 16'd3, 1, 16'd58982, 32'sh0000_0000, 32'sh0000_0000, 31'h0000_0001, 0},
		'{1, 16'd4, 1, 16'd6553, 32'sh4000_0000, 32'sh4000_0000, 31'h4000_0000, 0},
		'{1, 16'd31, 1, 16'd58983, 32'sh0000_0000, -32'sh0000_0001, 31'h2AAA_AAAA, 0},
		'{1, 16'd7, 1, 16'd1, -32'sh7FFF_FFFF, 32'sh0000_0000, 31'h7FFF_FFFF, 0}
	};

	// sender: directed table, then random stars in phases of new settings
	initial begin
		int mode;
		logic [30:0] rad;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].set_pts) write_reg(REG_STAR_POINTS, rows[i].pts);
			if (rows[i].set_ratio) write_reg(REG_INNER_RATIO, rows[i].ratio);
			send_star(rows[i].cx, rows[i].cy, rows[i].radius, rows[i].at_centre);
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 20 == 0) begin
				// mostly small stars keep the run short
				if ($urandom_range(0, 4) == 0) write_reg(REG_STAR_POINTS, 16'($urandom));
				else write_reg(REG_STAR_POINTS, 16'($urandom_range(0, 9)));
				write_reg(REG_INNER_RATIO, 16'($urandom));
			end
			mode = $urandom_range(0, 9);
			rad = 31'($urandom) >> $urandom_range(0, 30);
			if (mode == 0) rad = 31'h7FFF_FFFF;
			send_star(32'($urandom), 32'($urandom), rad, 0);
		end

		wait (pending_vertices.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (n_errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

	// receiver: random stalls, one long hold-off, check each vertex
	initial begin
		int stall;
		bit held;
		vertex_t e;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && n_vertices >= 150) begin
				held = 1;
				out_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
			out_ch.ready = 1'b0;
			repeat (stall) @(negedge clk);
			out_ch.ready = 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			n_vertices++;
			if (pending_vertices.size() == 0) begin
				$error("vertex with none expected: number %0d", out_ch.vertex_number);
				n_errors++;
			end else begin
				e = pending_vertices.pop_front();
				if (out_ch.vertex_x !== e.x) begin
					$error("vertex_x: expected %0d, got %0d", e.x, out_ch.vertex_x);
					n_errors++;
				end
				if (out_ch.vertex_y !== e.y) begin
					$error("vertex_y: expected %0d, got %0d", e.y, out_ch.vertex_y);
					n_errors++;
				end
				if (out_ch.vertex_number !== e.num) begin
					$error("vertex_number: expected %0d, got %0d", e.num,
						out_ch.vertex_number);
					n_errors++;
				end
				if (out_ch.last_vertex !== e.last) begin
					$error("last_vertex: expected %0d, got %0d", e.last, out_ch.last_vertex);
					n_errors++;
				end
			end
		end
	end

endmodule

/* sim.f */
rtl/spvg_pkg.sv
rtl/spvg_if.sv
rtl/spvg_ctrl.sv
rtl/spvg_datapath.sv
rtl/star_polygon_vertex_generator_core.sv
rtl/spvg_checker.sv
bench/star_polygon_vertex_generator_core_tb.sv
